// ----- design/hsla_pkg.sv -----
// Shared types, fixed-point constants and helper functions for the HSLA to RGBA converter.
// Depends on nothing; every other design file imports it.
package hsla_pkg;

  localparam int FRAC_BITS = 16;
  // One extra integer bit so that the value 1.0 itself is representable.
  localparam int FX_W      = FRAC_BITS + 1;
  localparam int NUM_LANES = 3;
  localparam int LANE_RED   = 0;
  localparam int LANE_GREEN = 1;
  localparam int LANE_BLUE  = 2;

  typedef logic [FX_W-1:0] fx_t;
  typedef logic [7:0]      byte_t;

  localparam fx_t FX_ONE        = fx_t'(1 << FRAC_BITS);
  localparam fx_t FX_HALF       = fx_t'((1 << FRAC_BITS) / 2);
  localparam fx_t FX_THIRD      = fx_t'((1 << FRAC_BITS) / 3);
  localparam fx_t FX_TWO_THIRDS = fx_t'((2 * (1 << FRAC_BITS)) / 3);
  localparam logic [8:0] CH_MAX = 9'd255;

  // Segment of the hue ramp that a channel falls in.
  typedef enum logic [1:0] {
    RG_RISE,
    RG_HIGH,
    RG_FALL,
    RG_LOW
  } region_t;

  // Per-channel ramp selection and the slope factor that multiplies (m2 - m1).
  typedef struct packed {
    region_t rg;
    fx_t     k;
  } lane_t;

  typedef lane_t [NUM_LANES-1:0] lanes_t;

  typedef struct packed {
    fx_t    l;
    fx_t    s;
    fx_t    p;
    lanes_t lanes;
    byte_t  alpha;
  } prep_t;

  typedef struct packed {
    fx_t    m1;
    fx_t    m2;
    fx_t    diff;
    lanes_t lanes;
    byte_t  alpha;
  } mix_t;

  typedef fx_t fix_lut_t [256];

  // floor(v * ONE / 255) for every 8-bit code, built at elaboration.
  function automatic fix_lut_t build_fix_lut();
    fix_lut_t lut;
    for (int i = 0; i < 256; i++) begin
      lut[i] = fx_t'((longint'(i) << FRAC_BITS) / 255);
    end
    return lut;
  endfunction

  localparam fix_lut_t FIX_LUT = build_fix_lut();

  // Classifies a wrapped hue into its ramp segment and the slope factor.
  function automatic lane_t hue_lane(fx_t x);
    logic [FX_W+2:0] six_x;
    logic [FX_W:0]   two_x;
    logic [FX_W+1:0] three_x;
    fx_t             d;
    logic [FX_W+2:0] six_d;
    lane_t           ln;
    six_x   = ({3'b000, x} << 2) + ({3'b000, x} << 1);
    two_x   = {x, 1'b0};
    three_x = {1'b0, two_x} + {2'b00, x};
    d       = (FX_TWO_THIRDS > x) ? (FX_TWO_THIRDS - x) : '0;
    six_d   = ({3'b000, d} << 2) + ({3'b000, d} << 1);
    if (six_x < {3'b000, FX_ONE}) begin
      ln.rg = RG_RISE;
      ln.k  = six_x[FX_W-1:0];
    end else if (two_x < {1'b0, FX_ONE}) begin
      ln.rg = RG_HIGH;
      ln.k  = '0;
    end else if (three_x < {1'b0, FX_ONE, 1'b0}) begin
      ln.rg = RG_FALL;
      ln.k  = six_d[FX_W-1:0];
    end else begin
      ln.rg = RG_LOW;
      ln.k  = '0;
    end
    return ln;
  endfunction

endpackage

// ----- design/hsla_prep.sv -----
// Front two pipeline stages: input codes to fixed point, hue offsets, l*s product
// and per-channel ramp classification. Depends on hsla_pkg.
module hsla_prep import hsla_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  input  byte_t hue,
  input  byte_t saturation,
  input  byte_t lightness,
  input  byte_t alpha_in,
  output logic  out_valid,
  input  logic  out_ready,
  output prep_t out_data
);

  logic  a_v_r, b_v_r;
  logic  a_ready, b_ready;
  fx_t   a_h_r, a_hr_r, a_hb_r, a_s_r, a_l_r;
  byte_t a_alpha_r;
  fx_t   h_nxt, hr_nxt, hb_nxt;
  logic [FX_W:0] hr_sum;
  logic [2*FX_W-1:0] ls_prod;
  prep_t b_data_nxt, b_data_r;

  assign b_ready  = !b_v_r || out_ready;
  assign a_ready  = !a_v_r || b_ready;
  assign in_ready = a_ready;

  // Stage A: code to fixed point and the two offset hues.
  always_comb begin
    h_nxt  = FIX_LUT[hue];
    hr_sum = {1'b0, h_nxt} + {1'b0, FX_THIRD};
    hr_nxt = (hr_sum > {1'b0, FX_ONE}) ? fx_t'(hr_sum - {1'b0, FX_ONE}) : hr_sum[FX_W-1:0];
    hb_nxt = (h_nxt < FX_THIRD) ? (h_nxt + FX_ONE - FX_THIRD) : (h_nxt - FX_THIRD);
  end

  // Stage B: the l*s product and ramp segment of each channel.
  always_comb begin
    ls_prod                     = {{FX_W{1'b0}}, a_l_r} * {{FX_W{1'b0}}, a_s_r};
    b_data_nxt.l                = a_l_r;
    b_data_nxt.s                = a_s_r;
    b_data_nxt.p                = ls_prod[FRAC_BITS +: FX_W];
    b_data_nxt.lanes[LANE_RED]   = hue_lane(a_hr_r);
    b_data_nxt.lanes[LANE_GREEN] = hue_lane(a_h_r);
    b_data_nxt.lanes[LANE_BLUE]  = hue_lane(a_hb_r);
    b_data_nxt.alpha            = a_alpha_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      b_v_r <= 1'b0;
    end else begin
      if (a_ready) begin
        a_v_r <= in_valid;
      end
      if (b_ready) begin
        b_v_r <= a_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (a_ready && in_valid) begin
      a_h_r     <= h_nxt;
      a_hr_r    <= hr_nxt;
      a_hb_r    <= hb_nxt;
      a_s_r     <= FIX_LUT[saturation];
      a_l_r     <= FIX_LUT[lightness];
      a_alpha_r <= alpha_in;
    end
    if (b_ready && a_v_r) begin
      b_data_r <= b_data_nxt;
    end
  end

  assign out_valid = b_v_r;
  assign out_data  = b_data_r;

endmodule

// ----- design/hsla_mix.sv -----
// Middle pipeline stage: the m2 and m1 levels of the CSS HSL formula and their
// difference. Depends on hsla_pkg.
module hsla_mix import hsla_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  input  prep_t in_data,
  output logic  out_valid,
  input  logic  out_ready,
  output mix_t  out_data
);

  logic          v_r;
  logic [FX_W:0] m2_wide, two_l, m1_wide;
  fx_t           m2, m1;
  mix_t          data_nxt, data_r;

  assign in_ready = !v_r || out_ready;

  always_comb begin
    if (in_data.l <= FX_HALF) begin
      m2_wide = {1'b0, in_data.l} + {1'b0, in_data.p};
    end else begin
      m2_wide = {1'b0, in_data.l} + {1'b0, in_data.s} - {1'b0, in_data.p};
    end
    m2      = m2_wide[FX_W-1:0];
    two_l   = {in_data.l, 1'b0};
    m1_wide = two_l - {1'b0, m2};
    m1      = (two_l >= {1'b0, m2}) ? m1_wide[FX_W-1:0] : '0;
    data_nxt.m1    = m1;
    data_nxt.m2    = m2;
    data_nxt.diff  = (m2 > m1) ? (m2 - m1) : '0;
    data_nxt.lanes = in_data.lanes;
    data_nxt.alpha = in_data.alpha;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (in_ready) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data_r <= data_nxt;
    end
  end

  assign out_valid = v_r;
  assign out_data  = data_r;

endmodule

// ----- design/hsla_ramp.sv -----
// Last two pipeline stages: per-channel slope multiply, then ramp select and
// scaling to 8-bit codes in the output register. Depends on hsla_pkg.
module hsla_ramp import hsla_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  input  mix_t  in_data,
  output logic  out_valid,
  input  logic  out_ready,
  output byte_t red,
  output byte_t green,
  output byte_t blue,
  output byte_t alpha_out
);

  logic              d_v_r, e_v_r;
  logic              d_ready, e_ready;
  fx_t               pr_nxt [NUM_LANES];
  fx_t               d_pr_r [NUM_LANES];
  region_t           d_rg_r [NUM_LANES];
  fx_t               d_m1_r, d_m2_r;
  byte_t             d_alpha_r;
  logic [2*FX_W-1:0] prod [NUM_LANES];
  logic [FX_W:0]     sum [NUM_LANES];
  logic [FX_W:0]     c_wide [NUM_LANES];
  fx_t               c [NUM_LANES];
  logic [FX_W+7:0]   scaled [NUM_LANES];
  logic [8:0]        top [NUM_LANES];
  byte_t             ch_nxt [NUM_LANES];
  byte_t             ch_r [NUM_LANES];
  byte_t             e_alpha_r;

  assign e_ready  = !e_v_r || out_ready;
  assign d_ready  = !d_v_r || e_ready;
  assign in_ready = d_ready;

  // Stage D: (m2 - m1) times the slope factor of each channel.
  always_comb begin
    for (int i = 0; i < NUM_LANES; i++) begin
      prod[i]   = {{FX_W{1'b0}}, in_data.diff} * {{FX_W{1'b0}}, in_data.lanes[i].k};
      pr_nxt[i] = prod[i][FRAC_BITS +: FX_W];
    end
  end

  // Stage E: pick the ramp value, clamp to 1.0 and scale by 255.
  always_comb begin
    for (int i = 0; i < NUM_LANES; i++) begin
      sum[i] = {1'b0, d_m1_r} + {1'b0, d_pr_r[i]};
      case (d_rg_r[i])
        RG_RISE, RG_FALL: c_wide[i] = sum[i];
        RG_HIGH:          c_wide[i] = {1'b0, d_m2_r};
        default:          c_wide[i] = {1'b0, d_m1_r};
      endcase
      c[i]      = (c_wide[i] > {1'b0, FX_ONE}) ? FX_ONE : c_wide[i][FX_W-1:0];
      scaled[i] = {c[i], 8'h00} - {8'h00, c[i]};
      top[i]    = scaled[i][FRAC_BITS +: 9];
      ch_nxt[i] = (top[i] > CH_MAX) ? CH_MAX[7:0] : top[i][7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_v_r <= 1'b0;
      e_v_r <= 1'b0;
    end else begin
      if (d_ready) begin
        d_v_r <= in_valid;
      end
      if (e_ready) begin
        e_v_r <= d_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (d_ready && in_valid) begin
      for (int i = 0; i < NUM_LANES; i++) begin
        d_pr_r[i] <= pr_nxt[i];
        d_rg_r[i] <= in_data.lanes[i].rg;
      end
      d_m1_r    <= in_data.m1;
      d_m2_r    <= in_data.m2;
      d_alpha_r <= in_data.alpha;
    end
    if (e_ready && d_v_r) begin
      for (int i = 0; i < NUM_LANES; i++) begin
        ch_r[i] <= ch_nxt[i];
      end
      e_alpha_r <= d_alpha_r;
    end
  end

  assign out_valid = e_v_r;
  assign red       = ch_r[LANE_RED];
  assign green     = ch_r[LANE_GREEN];
  assign blue      = ch_r[LANE_BLUE];
  assign alpha_out = e_alpha_r;

endmodule

// ----- design/hsla_to_rgba_converter.sv -----
// HSLA to RGBA converter (CSS3 HSL algorithm), five-stage pipeline.
// Path: each input is registered in stages A and B, the mix register, then stages D and E.
// Throughput: one transfer per cycle while out_ready is high; every stage holds one item and advances whenever the
// stage after it is empty or moving, so a stall at the output backs up one stage at a time.
// Reset: synchronous, active-low rst_n clears all stage valid bits; data registers are not reset.
// Depends on hsla_pkg, hsla_prep, hsla_mix and hsla_ramp.
module hsla_to_rgba_converter import hsla_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  input  byte_t in_hue,
  input  byte_t in_saturation,
  input  byte_t in_lightness,
  input  byte_t in_alpha_in,
  output logic  out_valid,
  input  logic  out_ready,
  output byte_t out_red,
  output byte_t out_green,
  output byte_t out_blue,
  output byte_t out_alpha_out
);

  // Handshake between the front end and the level computation.
  logic  prep_valid, prep_ready;
  prep_t prep_data;
  // Handshake between the level computation and the channel ramps.
  logic  mix_valid, mix_ready;
  mix_t  mix_data;

  // Stages 1 and 2: fixed-point conversion of the codes, the red and blue hue
  // offsets with wrap into [0,1], the l*s product, and the ramp segment of
  // each channel's hue.
  hsla_prep u_prep (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .hue        (in_hue),
    .saturation (in_saturation),
    .lightness  (in_lightness),
    .alpha_in   (in_alpha_in),
    .out_valid  (prep_valid),
    .out_ready  (prep_ready),
    .out_data   (prep_data)
  );

  // Stage 3: the m2 and m1 levels and their difference.
  hsla_mix u_mix (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (prep_valid),
    .in_ready  (prep_ready),
    .in_data   (prep_data),
    .out_valid (mix_valid),
    .out_ready (mix_ready),
    .out_data  (mix_data)
  );

  // Stages 4 and 5: one multiplier per channel for the sloped segments, then
  // the final select, clamp and scale into the output register. Alpha rides
  // along unchanged.
  hsla_ramp u_ramp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (mix_valid),
    .in_ready  (mix_ready),
    .in_data   (mix_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .red       (out_red),
    .green     (out_green),
    .blue      (out_blue),
    .alpha_out (out_alpha_out)
  );

endmodule

// ----- design/hsla_checker.sv -----
// Port-level assertions for the HSLA to RGBA converter, bound to the top level.
// Depends on hsla_pkg and hsla_to_rgba_converter.
module hsla_checker import hsla_pkg::*; (
  input logic  clk,
  input logic  rst_n,
  input logic  in_valid,
  input logic  in_ready,
  input byte_t in_hue,
  input byte_t in_saturation,
  input byte_t in_lightness,
  input byte_t in_alpha_in,
  input logic  out_valid,
  input logic  out_ready,
  input byte_t out_red,
  input byte_t out_green,
  input byte_t out_blue,
  input byte_t out_alpha_out
);

  // An offered pixel waits unchanged until it is transferred.
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_hue) && $stable(in_saturation)
      && $stable(in_lightness) && $stable(in_alpha_in))
    else $error("input pixel changed while waiting");

  // A stalled result stays put until it is transferred.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_red) && $stable(out_green)
      && $stable(out_blue) && $stable(out_alpha_out))
    else $error("result changed while stalled");

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // Input backpressure only arises from a full pipeline stalled at the output.
  a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without output backpressure");

  // A result appearing at an empty output was preceded by a matching input transfer.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready, 5))
    else $error("result appeared without a matching input transfer");

endmodule

bind hsla_to_rgba_converter hsla_checker u_hsla_checker (.*);
